>>> rtl/core/iff_pkg.sv
// Package with the shared types, codes and helpers of the integer field formatter.
`default_nettype none
package iff_pkg;

  localparam int IFF_WIDTH_MAX = 63;
  localparam int NDIG = 10;

  localparam logic [1:0] FUNC_SDEC = 2'd0;
  localparam logic [1:0] FUNC_UDEC = 2'd1;
  localparam logic [1:0] FUNC_HEX  = 2'd2;
  localparam logic [1:0] FUNC_CHAR = 2'd3;

  localparam logic [2:0] FLAG_NONE  = 3'd0;
  localparam logic [2:0] FLAG_PLUS  = 3'd1;
  localparam logic [2:0] FLAG_MINUS = 3'd2;
  localparam logic [2:0] FLAG_SPACE = 3'd3;
  localparam logic [2:0] FLAG_ZERO  = 3'd4;
  localparam logic [2:0] FLAG_HASH  = 3'd5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] value;
    logic [2:0]  flag;
    logic [5:0]  field_width;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_req_t;

  typedef enum logic [1:0] {
    MODE_LEFT,
    MODE_ZERO,
    MODE_RIGHT
  } mode_t;

  typedef struct packed {
    logic load;
    logic step;
    logic size;
    logic emit;
  } iff_cmd_t;

  typedef struct packed {
    logic is_dec;
    logic conv_done;
    logic out_free;
    logic at_last;
  } iff_stat_t;

  function automatic logic [7:0] glyph(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/iff_ctrl.sv
// Controller state machine that sequences loading, conversion, sizing and emission.
`default_nettype none
module iff_ctrl
  import iff_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire iff_stat_t stat,
  output iff_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SIZE = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.is_dec ? ST_CONV : ST_SIZE;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (stat.conv_done) begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: begin
        cmd.size  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.at_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/iff_dp.sv
// Datapath with the binary to decimal converter, field layout and output register.
`default_nettype none
module iff_dp
  import iff_pkg::*;
#(
  parameter int WIDTH_MAX = IFF_WIDTH_MAX
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_req_t  in_req,
  input  wire iff_cmd_t cmd,
  output iff_stat_t     stat,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_req_t      out_req
);

  localparam logic [5:0] WMAX = 6'(WIDTH_MAX);

  logic [3:0]  dig_r [NDIG];
  logic [31:0] mag_r;
  logic [4:0]  cnt_r;
  logic [7:0]  char_r;
  logic [7:0]  sign_r;
  logic [1:0]  npre_r;
  logic [5:0]  w_r;
  logic        is_char_r;
  mode_t       mode_r;
  logic [3:0]  nd_r;
  logic [5:0]  b1_r;
  logic [5:0]  b2_r;
  logic [5:0]  total_r;
  logic [5:0]  pos_r;
  logic        out_valid_r;
  out_req_t    out_req_r;

  logic [3:0]  adj [NDIG];
  logic [3:0]  nd_c;
  logic [5:0]  body_c;
  logic [5:0]  pad_c;
  logic [7:0]  ch_c;
  logic        neg_c;

  assign neg_c = (in_req.func == FUNC_SDEC) && in_req.value[31];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = (dig_r[i] >= 4'd5) ? dig_r[i] + 4'd3 : dig_r[i];
    end
  end

  always_comb begin
    nd_c = 4'd1;
    for (int i = 0; i < NDIG; i++) begin
      if (dig_r[i] != 4'd0) begin
        nd_c = 4'(i + 1);
      end
    end
    if (is_char_r) begin
      nd_c = 4'd1;
    end
    body_c = {4'd0, npre_r} + {2'd0, nd_c};
    pad_c  = (w_r > body_c) ? w_r - body_c : 6'd0;
  end

  function automatic logic [7:0] pre_char(input logic [5:0] k, input logic [1:0] np,
                                          input logic [7:0] sg);
    logic [7:0] c;
    if (np == 2'd2) begin
      c = (k == 6'd0) ? CH_ZERO : CH_X;
    end else begin
      c = sg;
    end
    return c;
  endfunction

  always_comb begin
    logic [5:0] off;
    logic [5:0] idx;
    logic [7:0] dch;
    off = 6'd0;
    unique case (mode_r)
      MODE_LEFT:  off = pos_r - b1_r;
      MODE_ZERO:  off = pos_r - b2_r;
      MODE_RIGHT: off = pos_r - b2_r;
      default:    off = 6'd0;
    endcase
    idx = {2'd0, nd_r} - 6'd1 - off;
    if (is_char_r) begin
      dch = char_r;
    end else if (idx < 6'(NDIG)) begin
      dch = glyph(dig_r[idx[3:0]]);
    end else begin
      dch = CH_ZERO;
    end
    ch_c = CH_SPACE;
    unique case (mode_r)
      MODE_LEFT: begin
        if (pos_r < b1_r) begin
          ch_c = pre_char(pos_r, npre_r, sign_r);
        end else if (pos_r < b2_r) begin
          ch_c = dch;
        end else begin
          ch_c = CH_SPACE;
        end
      end
      MODE_ZERO: begin
        if (pos_r < b1_r) begin
          ch_c = pre_char(pos_r, npre_r, sign_r);
        end else if (pos_r < b2_r) begin
          ch_c = CH_ZERO;
        end else begin
          ch_c = dch;
        end
      end
      MODE_RIGHT: begin
        if (pos_r < b1_r) begin
          ch_c = CH_SPACE;
        end else if (pos_r < b2_r) begin
          ch_c = pre_char(pos_r - b1_r, npre_r, sign_r);
        end else begin
          ch_c = dch;
        end
      end
      default: begin
        ch_c = CH_SPACE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt_r     <= 5'd0;
      char_r    <= in_req.value[7:0];
      is_char_r <= (in_req.func == FUNC_CHAR);
      w_r       <= (in_req.field_width > WMAX) ? WMAX : in_req.field_width;
      mag_r     <= neg_c ? 32'd0 - in_req.value : in_req.value;
      for (int i = 0; i < 8; i++) begin
        dig_r[i] <= (in_req.func == FUNC_HEX) ? in_req.value[i*4 +: 4] : 4'd0;
      end
      dig_r[8] <= 4'd0;
      dig_r[9] <= 4'd0;
      if (neg_c) begin
        npre_r <= 2'd1;
        sign_r <= CH_MINUS;
      end else if (in_req.func == FUNC_SDEC && in_req.flag == FLAG_PLUS) begin
        npre_r <= 2'd1;
        sign_r <= CH_PLUS;
      end else if (in_req.func == FUNC_HEX && in_req.flag == FLAG_HASH) begin
        npre_r <= 2'd2;
        sign_r <= CH_ZERO;
      end else begin
        npre_r <= 2'd0;
        sign_r <= CH_SPACE;
      end
      if (in_req.flag == FLAG_MINUS) begin
        mode_r <= MODE_LEFT;
      end else if (in_req.flag == FLAG_ZERO) begin
        mode_r <= MODE_ZERO;
      end else begin
        mode_r <= MODE_RIGHT;
      end
    end else if (cmd.step) begin
      cnt_r <= cnt_r + 5'd1;
      mag_r <= {mag_r[30:0], 1'b0};
      dig_r[0] <= {adj[0][2:0], mag_r[31]};
      for (int i = 1; i < NDIG; i++) begin
        dig_r[i] <= {adj[i][2:0], adj[i-1][3]};
      end
    end
    if (cmd.size) begin
      nd_r    <= nd_c;
      pos_r   <= 6'd0;
      total_r <= (w_r > body_c) ? w_r : body_c;
      unique case (mode_r)
        MODE_LEFT: begin
          b1_r <= {4'd0, npre_r};
          b2_r <= body_c;
        end
        MODE_ZERO: begin
          b1_r <= {4'd0, npre_r};
          b2_r <= {4'd0, npre_r} + pad_c;
        end
        default: begin
          b1_r <= pad_c;
          b2_r <= pad_c + {4'd0, npre_r};
        end
      endcase
    end else if (cmd.emit) begin
      pos_r <= pos_r + 6'd1;
    end
    if (cmd.emit) begin
      out_req_r.out_char <= ch_c;
      out_req_r.last     <= stat.at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.is_dec    = (in_req.func == FUNC_SDEC) || (in_req.func == FUNC_UDEC);
  assign stat.conv_done = (cnt_r == 5'd31);
  assign stat.out_free  = !out_valid_r || !out_stall;
  assign stat.at_last   = (pos_r == total_r - 6'd1);

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule
`default_nettype wire

>>> rtl/core/integer_field_formatter.sv
// Top level of the integer field formatter: controller and datapath.
`default_nettype none
// The block takes one request holding a conversion kind, a 32-bit value, a flag and a
// field width, and returns the characters of the padded field one request at a time,
// with last set on the final one. A decimal request is loaded, runs through the shift
// and add-three converter and then has its field sized; after that one character
// leaves per cycle while the output side keeps taking them. Hex and character requests
// skip the converter. Emission waits while a waiting character is held off. A new
// request is taken once the final character has been loaded into the output register.
module integer_field_formatter
  import iff_pkg::*;
#(
  parameter int WIDTH_MAX = IFF_WIDTH_MAX
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire in_req_t in_req,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_req_t     out_req
);

  iff_cmd_t  cmd;
  iff_stat_t stat;

  iff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  iff_dp #(
    .WIDTH_MAX (WIDTH_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

endmodule
`default_nettype wire
